>>> hw/rtl/tuvc_pkg.sv
// Package for the UV square triangle clipper: vertex, triangle and result
// types, constants and the outcode and clip distance helpers.
// No dependencies.
package tuvc_pkg;

   localparam int DEF_MAX_POLY_VERTS = 8;
   localparam int DEF_FRAC_BITS      = 16;
   localparam int T_BITS             = 28;
   localparam int DIST_W             = 34;
   localparam int MAX_EMIT           = 7;
   localparam int NUM_CRD            = 5;
   localparam int QUEUE_DEPTH        = 2;

   localparam int CRD_X = 0;
   localparam int CRD_Y = 1;
   localparam int CRD_Z = 2;
   localparam int CRD_U = 3;
   localparam int CRD_V = 4;

   localparam logic [1:0] EDGE_UMIN = 2'd0;
   localparam logic [1:0] EDGE_UMAX = 2'd1;
   localparam logic [1:0] EDGE_VMIN = 2'd2;
   localparam logic [1:0] EDGE_VMAX = 2'd3;

   typedef struct packed {
      logic [NUM_CRD-1:0][31:0] crd;
      logic [31:0]              color;
   } vert_type;

   typedef struct packed {
      vert_type [2:0] vtx;
      logic [3:0]     comb;
      logic [3:0]     common;
   } tri_type;

   typedef struct packed {
      vert_type   vtx;
      logic [2:0] poly_count;
      logic       last_vertex;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_LOAD, ST_PREV, ST_READ, ST_TEST, ST_DIV, ST_MUL, ST_XWR,
      ST_COPY, ST_EDGE, ST_EMIT
   } back_state_type;

   // bit0 u<0, bit1 u>one, bit2 v<0, bit3 v>one
   function automatic logic [3:0] outcode(vert_type vt, logic [31:0] one);
      logic [3:0] c;
      c = 4'b0;
      if ($signed(vt.crd[CRD_U]) < 0) c[0] = 1'b1;
      else if ($signed(vt.crd[CRD_U]) > $signed(one)) c[1] = 1'b1;
      if ($signed(vt.crd[CRD_V]) < 0) c[2] = 1'b1;
      else if ($signed(vt.crd[CRD_V]) > $signed(one)) c[3] = 1'b1;
      return c;
   endfunction

   function automatic logic signed [DIST_W-1:0] edge_dist(vert_type vt,
         logic [1:0] edge_sel, logic [31:0] one);
      logic signed [DIST_W-1:0] u, v, o, d;
      u = DIST_W'($signed(vt.crd[CRD_U]));
      v = DIST_W'($signed(vt.crd[CRD_V]));
      o = DIST_W'($signed({1'b0, one}));
      case (edge_sel)
         EDGE_UMIN: d = u;
         EDGE_UMAX: d = o - u;
         EDGE_VMIN: d = v;
         EDGE_VMAX: d = o - v;
         default:   d = u;
      endcase
      return d;
   endfunction

   // lowest set bit of an edge mask
   function automatic logic [1:0] first_edge(logic [3:0] m);
      logic [1:0] e;
      e = EDGE_VMAX;
      if (m[2]) e = EDGE_VMIN;
      if (m[1]) e = EDGE_UMAX;
      if (m[0]) e = EDGE_UMIN;
      return e;
   endfunction

endpackage

>>> hw/rtl/tuvc_fifo.sv
// Small synchronous queue with full and empty flags.
// No dependencies.
module tuvc_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] din,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] dout,
   output logic             empty
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign full    = (cnt_ff == CW'(DEPTH));
   assign empty   = (cnt_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign dout    = mem_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) wr_in = (wr_ff == PW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      if (do_pop)  rd_in = (rd_ff == PW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      if (do_push && !do_pop) cnt_in = cnt_ff + 1'b1;
      else if (do_pop && !do_push) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ff] <= din;
   end
endmodule

>>> hw/rtl/tuvc_front.sv
// Front end: gathers three vertices, forms outcodes and queues the triangle.
// Depends on tuvc_pkg.
module tuvc_front import tuvc_pkg::*; #(
   parameter int FRAC_BITS = DEF_FRAC_BITS
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  vert_type vtx,
   output logic     full,
   output logic     q_push,
   output tri_type  q_data,
   input  logic     q_full
);
   localparam logic [31:0] ONE = 32'(1) << FRAC_BITS;

   logic [1:0]     corner_count_ff, corner_count_in;
   vert_type [1:0] corner_ff;
   logic [1:0][3:0] corner_outcodes_ff;
   logic [3:0]     oc_new;
   logic           accept;

   assign full   = (corner_count_ff == 2'd2) && q_full;
   assign accept = push && !full;
   assign oc_new = outcode(vtx, ONE);
   assign q_push = accept && (corner_count_ff == 2'd2);

   always_comb begin
      q_data.vtx[0] = corner_ff[0];
      q_data.vtx[1] = corner_ff[1];
      q_data.vtx[2] = vtx;
      q_data.comb   = corner_outcodes_ff[0] | corner_outcodes_ff[1] | oc_new;
      q_data.common = corner_outcodes_ff[0] & corner_outcodes_ff[1] & oc_new;
      corner_count_in = corner_count_ff;
      if (accept) corner_count_in = (corner_count_ff == 2'd2) ? 2'd0 : corner_count_ff + 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         corner_count_ff    <= '0;
         corner_outcodes_ff <= '0;
      end else begin
         corner_count_ff <= corner_count_in;
         if (accept && corner_count_ff != 2'd2)
            corner_outcodes_ff[corner_count_ff[0]] <= oc_new;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && corner_count_ff != 2'd2) corner_ff[corner_count_ff[0]] <= vtx;
   end
endmodule

>>> hw/rtl/tuvc_div.sv
// Restoring divider for the crossing ratio: floor(num * 2^T_BITS / den),
// with num <= den, one quotient bit per cycle.
// Depends on tuvc_pkg.
module tuvc_div import tuvc_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [DIST_W-2:0]   num,
   input  logic [DIST_W-2:0]   den,
   output logic                busy,
   output logic [T_BITS:0]     quot
);
   localparam int SW = $clog2(T_BITS + 1);

   logic                busy_ff;
   logic [SW-1:0]       step_ff;
   logic [DIST_W-1:0]   rem_ff, shifted;
   logic [DIST_W-2:0]   den_ff;
   logic [T_BITS:0]     quot_ff;
   logic                ge0, bit_in;

   assign busy    = busy_ff;
   assign quot    = quot_ff;
   assign ge0     = (num >= den);
   assign shifted = rem_ff << 1;
   assign bit_in  = (shifted >= DIST_W'(den_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         step_ff <= SW'(T_BITS);
      end else if (busy_ff) begin
         step_ff <= step_ff - 1'b1;
         if (step_ff == SW'(1)) busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         den_ff  <= den;
         quot_ff <= {{T_BITS{1'b0}}, ge0};
         rem_ff  <= ge0 ? DIST_W'(num - den) : DIST_W'(num);
      end else if (busy_ff) begin
         quot_ff <= {quot_ff[T_BITS-1:0], bit_in};
         rem_ff  <= bit_in ? shifted - DIST_W'(den_ff) : shifted;
      end
   end
endmodule

>>> hw/rtl/tuvc_back.sv
// Back end: loads a queued triangle into a polygon buffer, clips it edge by
// edge and emits the surviving polygon. Depends on tuvc_pkg and tuvc_div.
module tuvc_back import tuvc_pkg::*; #(
   parameter int MAX_POLY_VERTS = DEF_MAX_POLY_VERTS,
   parameter int FRAC_BITS      = DEF_FRAC_BITS
) (
   input  logic    clock,
   input  logic    reset,
   input  tri_type q_data,
   input  logic    q_empty,
   output logic    q_pop,
   output logic    out_push,
   output rsp_type out_data,
   input  logic    out_full
);
   localparam int          IW  = $clog2(MAX_POLY_VERTS);
   localparam int          CW  = $clog2(MAX_POLY_VERTS + 1);
   localparam logic [31:0] ONE = 32'(1) << FRAC_BITS;

   back_state_type state_ff, state_in;

   vert_type poly_ff [2][MAX_POLY_VERTS];

   logic [1:0]    load_ff;
   logic          src_ff;
   logic [CW-1:0] n_ff, cnt_ff;
   logic [IW-1:0] i_ff;
   logic [2:0]    e_ff, k_ff;
   logic [1:0]    edge_ff;
   logic [3:0]    mask_ff;
   vert_type      prev_ff, cur_ff, cross_ff;
   logic signed [62:0] prod_ff;

   logic          rd_bank;
   logic [IW-1:0] rd_idx;
   vert_type      rd_vtx;
   logic          wr_en;
   vert_type      wr_vtx;
   logic signed [DIST_W-1:0] dp, dc;
   logic          pin, cin, room, last_cur, last_emit;
   logic [2:0]    n_emit;
   logic [3:0]    mask_left;
   logic          div_start, div_busy;
   logic [DIST_W-2:0] div_num, div_den;
   logic [T_BITS:0]   t_q;
   logic signed [32:0] diff;
   logic signed [62:0] rnd;
   vert_type      snapped;

   tuvc_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .busy  (div_busy),
      .quot  (t_q)
   );

   assign dp        = edge_dist(prev_ff, edge_ff, ONE);
   assign dc        = edge_dist(cur_ff, edge_ff, ONE);
   assign pin       = !dp[DIST_W-1];
   assign cin       = !dc[DIST_W-1];
   assign room      = (cnt_ff < CW'(MAX_POLY_VERTS));
   assign last_cur  = (CW'(i_ff) + 1'b1 == n_ff);
   assign n_emit    = (n_ff > CW'(MAX_EMIT)) ? 3'(MAX_EMIT) : n_ff[2:0];
   assign last_emit = (e_ff + 3'd1 == n_emit);
   assign mask_left = mask_ff & ~(4'b1 << edge_ff);
   assign div_num   = dp[DIST_W-1] ? (DIST_W-1)'(-dp) : (DIST_W-1)'(dp);
   assign div_den   = dp[DIST_W-1] ? (DIST_W-1)'(dc - dp) : (DIST_W-1)'(dp - dc);
   assign rd_vtx    = poly_ff[rd_bank][rd_idx];

   // one coordinate per cycle through the multiplier
   assign diff = $signed({cur_ff.crd[k_ff][31], cur_ff.crd[k_ff]})
               - $signed({prev_ff.crd[k_ff][31], prev_ff.crd[k_ff]});
   assign rnd  = prod_ff + (63'sd1 <<< (T_BITS - 1));

   always_comb begin
      snapped = cross_ff;
      case (edge_ff)
         EDGE_UMIN: snapped.crd[CRD_U] = '0;
         EDGE_UMAX: snapped.crd[CRD_U] = ONE;
         EDGE_VMIN: snapped.crd[CRD_V] = '0;
         EDGE_VMAX: snapped.crd[CRD_V] = ONE;
         default:   snapped.crd[CRD_U] = '0;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (!q_empty) state_in = ST_LOAD;
         ST_LOAD: begin
            if (load_ff == 2'd2) begin
               if (q_data.common != 4'b0) state_in = ST_IDLE;
               else if (q_data.comb == 4'b0) state_in = ST_EMIT;
               else state_in = ST_PREV;
            end
         end
         ST_PREV: state_in = ST_READ;
         ST_READ: state_in = ST_TEST;
         ST_TEST: state_in = (pin != cin && room) ? ST_DIV : ST_COPY;
         ST_DIV:  if (!div_busy) state_in = ST_MUL;
         ST_MUL:  if (k_ff == 3'(NUM_CRD)) state_in = ST_XWR;
         ST_XWR:  state_in = ST_COPY;
         ST_COPY: state_in = last_cur ? ST_EDGE : ST_READ;
         ST_EDGE: begin
            if (cnt_ff < CW'(3)) state_in = ST_IDLE;
            else if (mask_left != 4'b0) state_in = ST_PREV;
            else state_in = ST_EMIT;
         end
         ST_EMIT: if (!out_full && last_emit) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      q_pop     = 1'b0;
      out_push  = 1'b0;
      div_start = 1'b0;
      wr_en     = 1'b0;
      wr_vtx    = cur_ff;
      rd_bank   = src_ff;
      rd_idx    = i_ff;
      case (state_ff)
         ST_LOAD: begin
            wr_en  = 1'b1;
            wr_vtx = q_data.vtx[load_ff];
            q_pop  = (load_ff == 2'd2);
         end
         ST_PREV: rd_idx = IW'(n_ff - 1'b1);
         ST_TEST: div_start = (pin != cin) && room;
         ST_XWR: begin
            wr_en  = 1'b1;
            wr_vtx = snapped;
         end
         ST_COPY: wr_en = cin && room;
         ST_EMIT: begin
            rd_idx   = IW'(e_ff);
            out_push = !out_full;
         end
         default: ;
      endcase
      out_data.vtx         = rd_vtx;
      out_data.poly_count  = n_emit;
      out_data.last_vertex = last_emit;
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_ff <= '0;
         e_ff    <= '0;
         k_ff    <= '0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               load_ff <= '0;
               e_ff    <= '0;
            end
            ST_LOAD: begin
               load_ff <= load_ff + 2'd1;
               if (load_ff == 2'd2) begin
                  src_ff  <= 1'b0;
                  n_ff    <= CW'(3);
                  mask_ff <= q_data.comb;
                  edge_ff <= first_edge(q_data.comb);
               end
            end
            ST_PREV: begin
               prev_ff <= rd_vtx;
               i_ff    <= '0;
               cnt_ff  <= '0;
            end
            ST_READ: cur_ff <= rd_vtx;
            ST_TEST: k_ff <= '0;
            ST_MUL: begin
               k_ff <= k_ff + 3'd1;
               if (k_ff < 3'(NUM_CRD))
                  prod_ff <= diff * $signed({1'b0, t_q});
               if (k_ff != 3'd0)
                  cross_ff.crd[k_ff - 3'd1] <= prev_ff.crd[k_ff - 3'd1]
                     + 32'(rnd >>> T_BITS);
               cross_ff.color <= prev_ff.color;
            end
            ST_XWR: cnt_ff <= cnt_ff + 1'b1;
            ST_COPY: begin
               if (cin && room) cnt_ff <= cnt_ff + 1'b1;
               prev_ff <= cur_ff;
               i_ff    <= i_ff + 1'b1;
            end
            ST_EDGE: begin
               n_ff    <= cnt_ff;
               src_ff  <= !src_ff;
               mask_ff <= mask_left;
               edge_ff <= first_edge(mask_left);
               e_ff    <= '0;
            end
            ST_EMIT: if (!out_full) e_ff <= e_ff + 3'd1;
            default: ;
         endcase
      end
   end

   // loads go to bank 0; clip results go to the bank opposite the source
   always_ff @(posedge clock) begin
      if (wr_en) begin
         if (state_ff == ST_LOAD) poly_ff[1'b0][IW'(load_ff)] <= wr_vtx;
         else poly_ff[!src_ff][cnt_ff[IW-1:0]] <= wr_vtx;
      end
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(MAX_POLY_VERTS)) else $error("polygon count overflow");
   a_div_den: assert property (@(posedge clock) disable iff (reset)
      div_start |-> div_den != '0) else $error("crossing with zero divisor");
   a_mul_ready: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MUL |-> !div_busy) else $error("ratio used before ready");
   a_emit_done: assert property (@(posedge clock) disable iff (reset)
      out_push && out_data.last_vertex |=> state_ff == ST_IDLE)
      else $error("emission continued past last vertex");
   a_emit_count: assert property (@(posedge clock) disable iff (reset)
      out_push |-> out_data.poly_count >= 3'd3) else $error("short polygon emitted");
endmodule

>>> hw/rtl/triangle_uv_square_clipper.sv
// Clips triangles against the unit UV square, one vertex per transaction.
// Vertices are taken one per cycle unless req_full is high; a triangle that needs clipping then goes
// through idle and load, then per crossed edge prev and edge, a read, test and copy
// per polygon vertex, a divide, multiply and write per crossing point, then emit.
// A two-entry triangle queue and a two-entry result queue decouple the sides.
// Synchronous reset clears the state machines and queue control state; polygon buffers are not cleared.
module triangle_uv_square_clipper import tuvc_pkg::*; #(
   parameter int MAX_POLY_VERTS = DEF_MAX_POLY_VERTS,
   parameter int FRAC_BITS      = DEF_FRAC_BITS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_pos_z,
   input  logic signed [31:0] req_tex_u,
   input  logic signed [31:0] req_tex_v,
   input  logic        [31:0] req_color,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic signed [31:0] rsp_out_x,
   output logic signed [31:0] rsp_out_y,
   output logic signed [31:0] rsp_out_z,
   output logic signed [31:0] rsp_out_u,
   output logic signed [31:0] rsp_out_v,
   output logic        [31:0] rsp_out_color,
   output logic        [2:0]  rsp_poly_count,
   output logic               rsp_last_vertex
);
   vert_type in_vtx;
   tri_type  tq_din, tq_dout;
   logic     tq_push, tq_full, tq_pop, tq_empty;
   rsp_type  oq_din, oq_dout;
   logic     oq_push, oq_full;

   always_comb begin
      in_vtx.crd[CRD_X] = req_pos_x;
      in_vtx.crd[CRD_Y] = req_pos_y;
      in_vtx.crd[CRD_Z] = req_pos_z;
      in_vtx.crd[CRD_U] = req_tex_u;
      in_vtx.crd[CRD_V] = req_tex_v;
      in_vtx.color      = req_color;
   end

   tuvc_front #(.FRAC_BITS(FRAC_BITS)) u_front (
      .clock  (clock),
      .reset  (reset),
      .push   (req_push),
      .vtx    (in_vtx),
      .full   (req_full),
      .q_push (tq_push),
      .q_data (tq_din),
      .q_full (tq_full)
   );

   tuvc_fifo #(.WIDTH($bits(tri_type)), .DEPTH(QUEUE_DEPTH)) u_tri_q (
      .clock (clock),
      .reset (reset),
      .push  (tq_push),
      .din   (tq_din),
      .full  (tq_full),
      .pop   (tq_pop),
      .dout  (tq_dout),
      .empty (tq_empty)
   );

   tuvc_back #(.MAX_POLY_VERTS(MAX_POLY_VERTS), .FRAC_BITS(FRAC_BITS)) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_data   (tq_dout),
      .q_empty  (tq_empty),
      .q_pop    (tq_pop),
      .out_push (oq_push),
      .out_data (oq_din),
      .out_full (oq_full)
   );

   tuvc_fifo #(.WIDTH($bits(rsp_type)), .DEPTH(QUEUE_DEPTH)) u_rsp_q (
      .clock (clock),
      .reset (reset),
      .push  (oq_push),
      .din   (oq_din),
      .full  (oq_full),
      .pop   (rsp_pop),
      .dout  (oq_dout),
      .empty (rsp_empty)
   );

   assign rsp_out_x       = oq_dout.vtx.crd[CRD_X];
   assign rsp_out_y       = oq_dout.vtx.crd[CRD_Y];
   assign rsp_out_z       = oq_dout.vtx.crd[CRD_Z];
   assign rsp_out_u       = oq_dout.vtx.crd[CRD_U];
   assign rsp_out_v       = oq_dout.vtx.crd[CRD_V];
   assign rsp_out_color   = oq_dout.vtx.color;
   assign rsp_poly_count  = oq_dout.poly_count;
   assign rsp_last_vertex = oq_dout.last_vertex;
endmodule

>>> tb/sv/tb_triangle_uv_square_clipper.sv
// Self-checking testbench for triangle_uv_square_clipper: streams vertices,
// predicts the clipped polygons in a behavioral model and compares every result.
// Depends on tuvc_pkg and the triangle_uv_square_clipper RTL.
`timescale 1ns / 100ps

module tb_triangle_uv_square_clipper;
   import tuvc_pkg::*;

   localparam int NVERT = 8;
   localparam int FRAC  = 16;
   localparam longint ONE = 64'sd1 << FRAC;
   localparam int CYCLE_LIMIT = 600000;

   typedef struct {
      logic [31:0] x, y, z, u, v, color;
   } vertex_type;

   typedef struct {
      logic [31:0] x, y, z, u, v, color;
      logic [2:0]  count;
      logic        last;
   } poly_vertex_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_push = 1'b0;
   logic req_full;
   logic signed [31:0] req_pos_x = '0, req_pos_y = '0, req_pos_z = '0;
   logic signed [31:0] req_tex_u = '0, req_tex_v = '0;
   logic [31:0] req_color = '0;
   logic rsp_empty;
   logic rsp_pop = 1'b0;
   logic signed [31:0] rsp_out_x, rsp_out_y, rsp_out_z, rsp_out_u, rsp_out_v;
   logic [31:0] rsp_out_color;
   logic [2:0]  rsp_poly_count;
   logic        rsp_last_vertex;

   triangle_uv_square_clipper dut (.*);

   always #5 clock = ~clock;

   vertex_type      pending_vertices[$];
   poly_vertex_type expected_vertices[$];
   int  error_count = 0;
   int  vertices_sent = 0;
   int  results_seen = 0;
   int  polygons_seen = 0;
   longint cycle_count = 0;
   int  push_idle_pct = 0;
   int  pop_idle_pct = 0;
   bit  hold_push = 1'b0;
   logic req_full_q = 1'b1;

   // clipper state
   int     corner_idx = 0;
   longint poly_crd[2][NVERT][5];
   logic [31:0] poly_col[2][NVERT];
   logic [3:0]  corner_code[3];

   function automatic logic [3:0] uv_outcode(longint u, longint v);
      logic [3:0] c;
      c = 4'b0;
      if (u < 0) c[0] = 1'b1;
      else if (u > ONE) c[1] = 1'b1;
      if (v < 0) c[2] = 1'b1;
      else if (v > ONE) c[3] = 1'b1;
      return c;
   endfunction

   function automatic longint boundary_dist(longint u, longint v, int e);
      case (e)
         0: return u;
         1: return ONE - u;
         2: return v;
         default: return ONE - v;
      endcase
   endfunction

   // clip buffer src against edge e into src^1, return vertex count
   function automatic int clip_against(int src, int n, int e);
      int dst, cnt, prev;
      longint dp, dc, num, den, t, prod, r;
      dst = src ^ 1;
      cnt = 0;
      prev = n - 1;
      dp = boundary_dist(poly_crd[src][prev][3], poly_crd[src][prev][4], e);
      for (int i = 0; i < n; i++) begin
         dc = boundary_dist(poly_crd[src][i][3], poly_crd[src][i][4], e);
         if ((dp >= 0) != (dc >= 0) && cnt < NVERT) begin
            num = dp >= 0 ? dp : -dp;
            den = dp >= 0 ? dp - dc : dc - dp;
            t = (num <<< 28) / den;
            for (int k = 0; k < 5; k++) begin
               prod = (poly_crd[src][i][k] - poly_crd[src][prev][k]) * t;
               r = (prod + (64'sd1 <<< 27)) >>> 28;
               poly_crd[dst][cnt][k] = poly_crd[src][prev][k] + r;
            end
            if (e == 0) poly_crd[dst][cnt][3] = 0;
            else if (e == 1) poly_crd[dst][cnt][3] = ONE;
            else if (e == 2) poly_crd[dst][cnt][4] = 0;
            else poly_crd[dst][cnt][4] = ONE;
            poly_col[dst][cnt] = poly_col[src][prev];
            cnt++;
         end
         if (dc >= 0 && cnt < NVERT) begin
            for (int k = 0; k < 5; k++) poly_crd[dst][cnt][k] = poly_crd[src][i][k];
            poly_col[dst][cnt] = poly_col[src][i];
            cnt++;
         end
         prev = i;
         dp = dc;
      end
      return cnt;
   endfunction

   task automatic predict_polygon(input vertex_type vt);
      int slot, n, src;
      logic [3:0] comb, common;
      poly_vertex_type pv;
      slot = corner_idx;
      poly_crd[0][slot][0] = longint'($signed(vt.x));
      poly_crd[0][slot][1] = longint'($signed(vt.y));
      poly_crd[0][slot][2] = longint'($signed(vt.z));
      poly_crd[0][slot][3] = longint'($signed(vt.u));
      poly_crd[0][slot][4] = longint'($signed(vt.v));
      poly_col[0][slot] = vt.color;
      corner_code[slot] = uv_outcode(poly_crd[0][slot][3], poly_crd[0][slot][4]);
      if (slot < 2) begin
         corner_idx = slot + 1;
         return;
      end
      corner_idx = 0;
      n = 3;
      src = 0;
      comb = corner_code[0] | corner_code[1] | corner_code[2];
      common = corner_code[0] & corner_code[1] & corner_code[2];
      if (common != 0) return;
      for (int e = 0; e < 4; e++) begin
         if (comb[e]) begin
            n = clip_against(src, n, e);
            if (n < 3) return;
            src ^= 1;
         end
      end
      if (n > MAX_EMIT) n = MAX_EMIT;
      for (int i = 0; i < n; i++) begin
         pv.x = poly_crd[src][i][0][31:0];
         pv.y = poly_crd[src][i][1][31:0];
         pv.z = poly_crd[src][i][2][31:0];
         pv.u = poly_crd[src][i][3][31:0];
         pv.v = poly_crd[src][i][4][31:0];
         pv.color = poly_col[src][i];
         pv.count = 3'(n);
         pv.last = (i == n - 1);
         expected_vertices.push_back(pv);
      end
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      error_count++;
      $display("mismatch %s: got %h expected %h (result %0d)", what, got, want,
               results_seen);
   endtask

   // driver
   always @(negedge clock) begin
      if (!reset) begin
         if (req_push && !req_full_q) begin
            predict_polygon(pending_vertices.pop_front());
            vertices_sent++;
         end
         if (pending_vertices.size() > 0 && !hold_push &&
             $urandom_range(99) >= push_idle_pct) begin
            req_push  <= 1'b1;
            req_pos_x <= pending_vertices[0].x;
            req_pos_y <= pending_vertices[0].y;
            req_pos_z <= pending_vertices[0].z;
            req_tex_u <= pending_vertices[0].u;
            req_tex_v <= pending_vertices[0].v;
            req_color <= pending_vertices[0].color;
         end else begin
            req_push <= 1'b0;
         end
         rsp_pop <= ($urandom_range(99) >= pop_idle_pct);
      end
   end

   // acceptance is judged on the rising edge and acted on at the next falling edge
   always @(posedge clock) begin
      req_full_q <= req_push ? req_full : 1'b1;
      cycle_count <= cycle_count + 1;
   end

   // monitor
   always @(posedge clock) begin
      poly_vertex_type w;
      if (!reset && rsp_pop && !rsp_empty) begin
         results_seen++;
         if (rsp_last_vertex) polygons_seen++;
         if (expected_vertices.size() == 0) begin
            error_count++;
            $display("unexpected result %0d", results_seen);
         end else begin
            w = expected_vertices.pop_front();
            if (rsp_out_x !== w.x) report_mismatch("x", rsp_out_x, w.x);
            if (rsp_out_y !== w.y) report_mismatch("y", rsp_out_y, w.y);
            if (rsp_out_z !== w.z) report_mismatch("z", rsp_out_z, w.z);
            if (rsp_out_u !== w.u) report_mismatch("u", rsp_out_u, w.u);
            if (rsp_out_v !== w.v) report_mismatch("v", rsp_out_v, w.v);
            if (rsp_out_color !== w.color)
               report_mismatch("color", rsp_out_color, w.color);
            if (rsp_poly_count !== w.count)
               report_mismatch("poly_count", 32'(rsp_poly_count), 32'(w.count));
            if (rsp_last_vertex !== w.last)
               report_mismatch("last_vertex", 32'(rsp_last_vertex), 32'(w.last));
         end
      end
   end

   always @(posedge clock) begin
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("== FAIL ==");
         $finish;
      end
   end

   function automatic logic [31:0] rand_uv();
      case ($urandom_range(5))
         0: return $urandom();
         1: return 32'($signed($urandom_range(2 * 65536)) - 32768);
         2: return $urandom_range(65536);
         3: return $urandom_range(1) ? 32'd0 : 32'h0001_0000;
         default: return 32'($signed($urandom_range(4 * 65536)) - 2 * 65536);
      endcase
   endfunction

   function automatic logic [31:0] rand_pos();
      if ($urandom_range(3) == 0) return $urandom();
      return 32'($signed($urandom_range(1 << 22)) - (1 << 21));
   endfunction

   task automatic add_vertex(input logic [31:0] x, y, z, u, v, c);
      vertex_type vt;
      vt.x = x; vt.y = y; vt.z = z; vt.u = u; vt.v = v; vt.color = c;
      pending_vertices.push_back(vt);
   endtask

   task automatic add_random_vertex();
      add_vertex(rand_pos(), rand_pos(), rand_pos(), rand_uv(), rand_uv(), $urandom());
   endtask

   task automatic wait_drained();
      while (pending_vertices.size() > 0 || req_push || expected_vertices.size() > 0)
         @(posedge clock);
      repeat (400) @(posedge clock);
   endtask

   initial begin
      int sent_mark;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // trivial accept with extreme positions and colors
      add_vertex(32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'h0, 32'h0, 32'h0);
      add_vertex(32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 32'h1_0000, 32'h0,
                 32'hffff_ffff);
      add_vertex(32'h0, 32'h0, 32'h8000_0000, 32'h1_0000, 32'h1_0000, 32'h5a5a_a5a5);
      // trivial reject, all left of u-min
      add_vertex(0, 0, 0, 32'h8000_0000, 32'h8000, 1);
      add_vertex(0, 0, 0, 32'hffff_ffff, 32'h0, 2);
      add_vertex(0, 0, 0, 32'hffff_0000, 32'h1_0000, 3);
      // straddles every edge of the square, large polygon
      add_vertex(32'h1234_0000, 32'h0, 32'h10000, 32'hffff_8000, 32'h8000, 4);
      add_vertex(32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'h8000, 32'hffff_0000, 5);
      add_vertex(32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 32'h2_0000, 32'h2_0000, 6);
      // extreme uv, clip across the whole range
      add_vertex(32'h1, 32'h2, 32'h3, 32'h7fff_ffff, 32'h8000, 7);
      add_vertex(32'h4, 32'h5, 32'h6, 32'h8000_0000, 32'h8000, 8);
      add_vertex(32'h7, 32'h8, 32'h9, 32'h8000, 32'h7fff_ffff, 9);
      // degenerate: only one vertex touches the square
      add_vertex(0, 0, 0, 32'h0, 32'h0, 10);
      add_vertex(0, 0, 0, 32'hffff_0000, 32'h0, 11);
      add_vertex(0, 0, 0, 32'h0, 32'hffff_0000, 12);

      push_idle_pct = 35;
      pop_idle_pct  = 88;
      for (int i = 0; i < 46; i++) add_random_vertex();
      wait_drained();
      // stop mid-stream, hold off until every polygon has drained, then resume
      sent_mark = vertices_sent;
      for (int i = 0; i < 46; i++) add_random_vertex();
      wait (vertices_sent >= sent_mark + 20);
      hold_push = 1'b1;
      @(posedge clock);
      while (req_push || expected_vertices.size() > 0) @(posedge clock);
      repeat (50) @(posedge clock);
      hold_push = 1'b0;
      wait_drained();
      push_idle_pct = 88;
      pop_idle_pct  = 35;
      for (int i = 0; i < 46; i++) add_random_vertex();
      wait_drained();
      push_idle_pct = 0;
      pop_idle_pct  = 0;
      for (int i = 0; i < 46; i++) add_random_vertex();
      wait_drained();

      $display("sent %0d vertices, checked %0d results in %0d polygons",
               vertices_sent, results_seen, polygons_seen);
      $display("covered trivial accept and reject, edge clips, a mid-stream pause and stalls");
      if (error_count == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

endmodule

>>> sim.f
hw/rtl/tuvc_pkg.sv
hw/rtl/tuvc_fifo.sv
hw/rtl/tuvc_front.sv
hw/rtl/tuvc_div.sv
hw/rtl/tuvc_back.sv
hw/rtl/triangle_uv_square_clipper.sv
tb/sv/tb_triangle_uv_square_clipper.sv
